>>> rtl/ssd_detection_decode_nms_macros.svh
// Assertion macros for the SSD decode and suppression block.
// Used by the top level only; no other dependencies.
`ifndef SSD_DETECTION_DECODE_NMS_MACROS_SVH
`define SSD_DETECTION_DECODE_NMS_MACROS_SVH

// same-cycle implication
`define SSDN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssdn check failed");

// next-cycle implication
`define SSDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssdn check failed");

`endif

>>> rtl/ssdn_pkg.sv
// Shared types, constants and codes for the SSD decode and suppression block.
// No dependencies.
`default_nettype none
package ssdn_pkg;

	localparam int MAX_CAND = 64;
	localparam int CAND_AW  = 6;
	localparam int CNT_W    = 7;
	localparam int ROW_W    = 152;

	localparam logic [7:0]         SWAP_LIMIT = 8'd200;
	localparam logic signed [31:0] NORM_LIMIT = 32'sd327680;

	localparam logic [1:0] OP_SCORE = 2'd0;
	localparam logic [1:0] OP_BOX   = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [2:0] REG_SCORE_THR   = 3'd0;
	localparam logic [2:0] REG_OVERLAP_THR = 3'd1;
	localparam logic [2:0] REG_IMG_W       = 3'd2;
	localparam logic [2:0] REG_IMG_H       = 3'd3;
	localparam logic [2:0] REG_BG_FIRST    = 3'd4;

	localparam logic [3:0] IS_NONE = 4'd0;
	localparam logic [3:0] IS_DIFF = 4'd1;
	localparam logic [3:0] IS_M1   = 4'd2;
	localparam logic [3:0] IS_M2   = 4'd3;
	localparam logic [3:0] IS_M3   = 4'd4;
	localparam logic [3:0] IS_M4   = 4'd5;
	localparam logic [3:0] IS_M5   = 4'd6;
	localparam logic [3:0] IS_M6   = 4'd7;
	localparam logic [3:0] IS_M7   = 4'd8;
	localparam logic [3:0] IS_CMP  = 4'd9;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [6:0]         class_column;
		logic [15:0]        class_score;
		logic signed [31:0] coord_a;
		logic signed [31:0] coord_b;
		logic signed [31:0] coord_c;
		logic signed [31:0] coord_d;
	} item_t;

	typedef struct packed {
		logic               present;
		logic [6:0]         det_class;
		logic [15:0]        confidence;
		logic signed [31:0] left;
		logic signed [31:0] top;
		logic signed [31:0] right;
		logic signed [31:0] bottom;
		logic               dropped_flag;
		logic               last;
	} det_t;

	typedef struct packed {
		logic [15:0] score_thr;
		logic [15:0] overlap_thr;
		logic [13:0] img_w;
		logic [13:0] img_h;
		logic        bg_first;
	} cfg_t;

	typedef struct packed {
		logic       score_upd;
		logic       box_eval;
		logic       div_start;
		logic       div_store;
		logic [1:0] coord_sel;
		logic       row_wr;
		logic       fe_init;
		logic       rd_en;
		logic       rd_bidx;
		logic       idx_clr;
		logic       idx_inc;
		logic       sel_clr;
		logic       sel_eval;
		logic       take_best;
		logic       a_load;
		logic       emit_held;
		logic       emit_end;
		logic [3:0] iou_step;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       qualify;
		logic       room;
		logic       norm;
		logic       div_done;
		logic       div_busy;
		logic       n_zero;
		logic       idx_last;
		logic       found;
		logic       best_supp;
		logic       b_cand;
		logic       uni_pos;
		logic       out_free;
	} st_t;

endpackage
`default_nettype wire

>>> rtl/ssd_detection_decode_nms.sv
// SSD detection decode with greedy per-class suppression: top level.
// Instantiates ssdn_ctrl and ssdn_dp; uses ssdn_pkg and the assertion macros header.
//
// item channel (item_valid/item_ready/item_data) takes score, box and frame-end
// transfers; det channel (det_valid/det_ready/det_data) returns kept detections.
// A score transfer is absorbed in idle, as is a box that is dropped. A normalized box
// is accepted, then its row is written; a pixel box first sends each of its four
// coordinates through the serial divider (start, 32 bits, store).
// Frame end selects the best open candidate with an n-entry scan through the
// candidate memory read port, then walks all n entries again, sending each open
// same-class entry through the IoU unit (one shared 35x35 multiplier).
// Results leave through an output register; the last kept detection is held
// back one step so it can carry last. A stalled det receiver stalls suppression
// only at the point of emission. item_ready is low while any item is at work.
// Reset clears all frame state and loads the register defaults; the candidate
// memory needs no clearing pass. APB registers at byte offsets 0,4,8,12,16.
`default_nettype none
`include "ssd_detection_decode_nms_macros.svh"
module ssd_detection_decode_nms (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire ssdn_pkg::item_t item_data,
	output logic                 det_valid,
	input  wire logic            det_ready,
	output ssdn_pkg::det_t       det_data,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [4:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	ssdn_pkg::cfg_t cfg_q;
	ssdn_pkg::cmd_t cmd;
	ssdn_pkg::st_t  st;
	logic           wr_en;
	logic           score_xfer;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_thr   <= 16'd19661;
			cfg_q.overlap_thr <= 16'd29491;
			cfg_q.img_w       <= 14'd300;
			cfg_q.img_h       <= 14'd300;
			cfg_q.bg_first    <= 1'b1;
		end else if (wr_en) begin
			case (paddr[4:2])
				ssdn_pkg::REG_SCORE_THR:   cfg_q.score_thr   <= pwdata[15:0];
				ssdn_pkg::REG_OVERLAP_THR: cfg_q.overlap_thr <= pwdata[15:0];
				ssdn_pkg::REG_IMG_W:       cfg_q.img_w       <= pwdata[13:0];
				ssdn_pkg::REG_IMG_H:       cfg_q.img_h       <= pwdata[13:0];
				ssdn_pkg::REG_BG_FIRST:    cfg_q.bg_first    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ssdn_pkg::REG_SCORE_THR:   prdata = {16'd0, cfg_q.score_thr};
			ssdn_pkg::REG_OVERLAP_THR: prdata = {16'd0, cfg_q.overlap_thr};
			ssdn_pkg::REG_IMG_W:       prdata = {18'd0, cfg_q.img_w};
			ssdn_pkg::REG_IMG_H:       prdata = {18'd0, cfg_q.img_h};
			ssdn_pkg::REG_BG_FIRST:    prdata = {31'd0, cfg_q.bg_first};
			default:                   prdata = '0;
		endcase
	end

	ssdn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid),
		.item_ready(item_ready), .st(st), .cmd(cmd)
	);

	ssdn_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .item(item_data),
		.cmd(cmd), .st(st), .det_valid(det_valid), .det_ready(det_ready),
		.det_data(det_data)
	);

	assign score_xfer = item_valid && item_ready && (item_data.opcode == ssdn_pkg::OP_SCORE);

	`SSDN_ASSERT_NOW(a_idle_div, clk, arst_n, item_ready, !st.div_busy)
	`SSDN_ASSERT_NEXT(a_score_1cyc, clk, arst_n, score_xfer, item_ready)
	`SSDN_ASSERT_NOW(a_empty_last, clk, arst_n, det_valid && !det_data.present, det_data.last)
endmodule
`default_nettype wire

>>> rtl/ssdn_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on nothing but its ports.
`default_nettype none
module ssdn_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] num,
	input  wire logic [13:0]        den,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      quo
);
	logic        busy_q, done_q, neg_q;
	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [13:0] rem_q, den_q;
	logic [14:0] trial;
	logic        ge;

	assign trial = {rem_q, dvd_q[31]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[31];
			dvd_q <= num[31] ? 32'(-num) : num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 14'(trial - {1'b0, den_q}) : trial[13:0];
			dvd_q <= {dvd_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = neg_q ? 32'(-dvd_q) : dvd_q;
endmodule
`default_nettype wire

>>> rtl/ssdn_dp.sv
// Datapath: anchor scoring, box decode, candidate memory, IoU unit, result registers.
// Depends on ssdn_pkg and ssdn_div.
`default_nettype none
module ssdn_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ssdn_pkg::cfg_t    cfg,
	input  wire ssdn_pkg::item_t   item,
	input  wire ssdn_pkg::cmd_t    cmd,
	output ssdn_pkg::st_t          st,
	output logic                   det_valid,
	input  wire logic              det_ready,
	output ssdn_pkg::det_t         det_data
);
	// frame state
	logic [15:0] best_q;
	logic [6:0]  bcls_q;
	logic [ssdn_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]  samp_q, yx_q, xy_q;
	logic        ovf_q, swap_q;

	// pending candidate
	logic signed [31:0] pend_q [4];
	logic [15:0] pscore_q;
	logic [6:0]  pcls_q;
	logic        pnorm_q;

	logic [ssdn_pkg::ROW_W-1:0] mem [ssdn_pkg::MAX_CAND];
	logic [ssdn_pkg::ROW_W-1:0] row_q;

	// scan state
	logic [ssdn_pkg::CAND_AW-1:0]  idx_q, bidx_q;
	logic [ssdn_pkg::MAX_CAND-1:0] proc_q, supp_q;
	logic        found_q;
	logic [15:0] sbest_q;

	// kept box
	logic signed [31:0] ax1_q, ay1_q, ax2_q, ay2_q;
	logic [6:0]  acls_q;
	logic [15:0] ascore_q;

	// IoU unit
	logic signed [32:0] dx_q, dy_q, wp_q, hp_q, wq_q, hq_q;
	logic signed [34:0] ma, mb;
	logic signed [69:0] mprod, prod_q, acc_q, inter_q;
	logic [85:0] rsum_q;

	ssdn_pkg::det_t held_q, det_q;
	logic held_v_q, det_v_q;

	// score item
	logic [6:0] s_cls;
	logic       s_skip, s_win;
	assign s_skip = cfg.bg_first && (item.class_column == 7'd0);
	assign s_cls  = item.class_column - {6'd0, cfg.bg_first};
	assign s_win  = (item.class_score > best_q) ||
		((item.class_score == best_q) && (s_cls < bcls_q));

	// box item
	logic signed [32:0] bw, bh;
	logic norm, qualify, room, geom_ok;
	assign bw      = 33'(item.coord_c) - 33'(item.coord_a);
	assign bh      = 33'(item.coord_d) - 33'(item.coord_b);
	assign geom_ok = (bh > 33'sd0) && (bw > 33'sd0);
	assign qualify = best_q >= cfg.score_thr;
	assign room    = !cnt_q[ssdn_pkg::CNT_W-1];

	function automatic logic in_norm(input logic signed [31:0] v);
		in_norm = (v > -ssdn_pkg::NORM_LIMIT) && (v < ssdn_pkg::NORM_LIMIT);
	endfunction
	assign norm = in_norm(item.coord_a) && in_norm(item.coord_b) &&
		in_norm(item.coord_c) && in_norm(item.coord_d);

	// divider
	logic [13:0] dden;
	logic        dbusy, ddone;
	logic signed [31:0] dquo;
	always_comb begin
		dden = cmd.coord_sel[0] ? cfg.img_h : cfg.img_w;
		if (dden == 14'd0) dden = 14'd1;
	end
	ssdn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(pend_q[cmd.coord_sel]), .den(dden),
		.busy(dbusy), .done(ddone), .quo(dquo)
	);

	// row unpack with swap
	logic rnorm, rsw;
	logic [6:0]  rcls;
	logic [15:0] rscore;
	logic signed [31:0] ra, rb, rc, rd, rx1, ry1, rx2, ry2;
	assign rnorm  = row_q[151];
	assign rcls   = row_q[150:144];
	assign rscore = row_q[143:128];
	assign rd     = row_q[127:96];
	assign rc     = row_q[95:64];
	assign rb     = row_q[63:32];
	assign ra     = row_q[31:0];
	assign rsw    = swap_q && rnorm;
	assign rx1    = rsw ? rb : ra;
	assign ry1    = rsw ? ra : rb;
	assign rx2    = rsw ? rd : rc;
	assign ry2    = rsw ? rc : rd;

	// intersection
	logic signed [31:0] ix1, iy1, ix2, iy2;
	logic signed [32:0] idx_w, idy_w;
	assign ix1   = (ax1_q > rx1) ? ax1_q : rx1;
	assign iy1   = (ay1_q > ry1) ? ay1_q : ry1;
	assign ix2   = (ax2_q < rx2) ? ax2_q : rx2;
	assign iy2   = (ay2_q < ry2) ? ay2_q : ry2;
	assign idx_w = 33'(ix2) - 33'(ix1);
	assign idy_w = 33'(iy2) - 33'(iy1);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.iou_step)
			ssdn_pkg::IS_M1: begin
				ma = 35'(wp_q);
				mb = 35'(hp_q);
			end
			ssdn_pkg::IS_M2: begin
				ma = 35'(wq_q);
				mb = 35'(hq_q);
			end
			ssdn_pkg::IS_M3: begin
				ma = 35'(dx_q);
				mb = 35'(dy_q);
			end
			ssdn_pkg::IS_M5: begin
				ma = {19'd0, cfg.overlap_thr};
				mb = {1'b0, acc_q[33:0]};
			end
			ssdn_pkg::IS_M6: begin
				ma = {19'd0, cfg.overlap_thr};
				mb = {1'b0, acc_q[67:34]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mprod = ma * mb;

	logic iou_gt;
	assign iou_gt = {4'd0, inter_q[65:0], 16'd0} > rsum_q;

	ssdn_pkg::det_t a_det, empty_det, held_last;
	always_comb begin
		a_det.present      = 1'b1;
		a_det.det_class    = acls_q;
		a_det.confidence   = ascore_q;
		a_det.left         = ax1_q;
		a_det.top          = ay1_q;
		a_det.right        = ax2_q;
		a_det.bottom       = ay2_q;
		a_det.dropped_flag = ovf_q;
		a_det.last         = 1'b0;
		empty_det              = '0;
		empty_det.dropped_flag = ovf_q;
		empty_det.last         = 1'b1;
		held_last      = held_q;
		held_last.last = 1'b1;
	end

	logic out_free;
	assign out_free = !det_v_q || det_ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '0;
			bcls_q   <= '0;
			cnt_q    <= '0;
			samp_q   <= '0;
			yx_q     <= '0;
			xy_q     <= '0;
			ovf_q    <= 1'b0;
			swap_q   <= 1'b0;
			proc_q   <= '0;
			supp_q   <= '0;
			found_q  <= 1'b0;
			held_v_q <= 1'b0;
			det_v_q  <= 1'b0;
			idx_q    <= '0;
			bidx_q   <= '0;
		end else begin
			if (cmd.score_upd && !s_skip && s_win) begin
				best_q <= item.class_score;
				bcls_q <= s_cls;
			end
			if (cmd.box_eval) begin
				best_q <= '0;
				bcls_q <= '0;
				if (qualify) begin
					if (samp_q < ssdn_pkg::SWAP_LIMIT) begin
						samp_q <= samp_q + 8'd1;
						if (geom_ok) begin
							yx_q <= yx_q + 8'd1;
							xy_q <= xy_q + 8'd1;
						end
					end
					if (!room) ovf_q <= 1'b1;
				end
			end
			if (cmd.row_wr) cnt_q <= cnt_q + 7'd1;
			if (cmd.fe_init) begin
				proc_q   <= '0;
				supp_q   <= '0;
				held_v_q <= 1'b0;
				swap_q   <= yx_q > xy_q;
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 6'd1;
			if (cmd.sel_clr) found_q <= 1'b0;
			if (cmd.sel_eval && !proc_q[idx_q] && (!found_q || rscore > sbest_q)) begin
				found_q <= 1'b1;
				bidx_q  <= idx_q;
			end
			if (cmd.take_best) proc_q[bidx_q] <= 1'b1;
			if (cmd.iou_step == ssdn_pkg::IS_CMP && iou_gt) supp_q[idx_q] <= 1'b1;
			if (cmd.emit_held) begin
				held_v_q <= 1'b1;
				if (held_v_q) det_v_q <= 1'b1;
				else if (det_ready) det_v_q <= 1'b0;
			end else if (cmd.emit_end) begin
				det_v_q  <= 1'b1;
				held_v_q <= 1'b0;
				best_q   <= '0;
				bcls_q   <= '0;
				cnt_q    <= '0;
				samp_q   <= '0;
				yx_q     <= '0;
				xy_q     <= '0;
				ovf_q    <= 1'b0;
			end else if (det_ready) begin
				det_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.box_eval) begin
			pend_q[0] <= item.coord_a;
			pend_q[1] <= item.coord_b;
			pend_q[2] <= item.coord_c;
			pend_q[3] <= item.coord_d;
			pscore_q  <= best_q;
			pcls_q    <= bcls_q;
			pnorm_q   <= norm;
		end
		if (cmd.div_store) pend_q[cmd.coord_sel] <= dquo;
		if (cmd.row_wr)
			mem[cnt_q[ssdn_pkg::CAND_AW-1:0]] <= {pnorm_q, pcls_q, pscore_q,
				pend_q[3], pend_q[2], pend_q[1], pend_q[0]};
		if (cmd.rd_en) row_q <= mem[cmd.rd_bidx ? bidx_q : idx_q];
		if (cmd.sel_eval && !proc_q[idx_q] && (!found_q || rscore > sbest_q))
			sbest_q <= rscore;
		if (cmd.a_load) begin
			ax1_q    <= rx1;
			ay1_q    <= ry1;
			ax2_q    <= rx2;
			ay2_q    <= ry2;
			acls_q   <= rcls;
			ascore_q <= rscore;
		end
		case (cmd.iou_step)
			ssdn_pkg::IS_DIFF: begin
				dx_q <= idx_w[32] ? 33'sd0 : idx_w;
				dy_q <= idy_w[32] ? 33'sd0 : idy_w;
				wp_q <= 33'(ax2_q) - 33'(ax1_q);
				hp_q <= 33'(ay2_q) - 33'(ay1_q);
				wq_q <= 33'(rx2) - 33'(rx1);
				hq_q <= 33'(ry2) - 33'(ry1);
			end
			ssdn_pkg::IS_M2: acc_q <= prod_q;
			ssdn_pkg::IS_M3: acc_q <= acc_q + prod_q;
			ssdn_pkg::IS_M4: begin
				acc_q   <= acc_q - prod_q;
				inter_q <= prod_q;
			end
			ssdn_pkg::IS_M6: rsum_q <= {36'd0, prod_q[49:0]};
			ssdn_pkg::IS_M7: rsum_q <= rsum_q + {2'd0, prod_q[49:0], 34'd0};
			default: ;
		endcase
		prod_q <= mprod;
		if (cmd.emit_held) begin
			held_q <= a_det;
			if (held_v_q) det_q <= held_q;
		end else if (cmd.emit_end) begin
			if (held_v_q) det_q <= held_last;
			else det_q <= empty_det;
		end
	end

	always_comb begin
		st.op        = item.opcode;
		st.qualify   = qualify;
		st.room      = room;
		st.norm      = norm;
		st.div_done  = ddone;
		st.div_busy  = dbusy;
		st.n_zero    = cnt_q == '0;
		st.idx_last  = {1'b0, idx_q} == (cnt_q - 7'd1);
		st.found     = found_q;
		st.best_supp = supp_q[bidx_q];
		st.b_cand    = !proc_q[idx_q] && !supp_q[idx_q] && (rcls == acls_q);
		st.uni_pos   = !acc_q[69] && (acc_q != '0);
		st.out_free  = out_free;
	end

	assign det_valid = det_v_q;
	assign det_data  = det_q;
endmodule
`default_nettype wire

>>> rtl/ssdn_ctrl.sv
// Controller state machine sequencing item intake, box decode and suppression.
// Depends on ssdn_pkg.
`default_nettype none
module ssdn_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire ssdn_pkg::st_t  st,
	output ssdn_pkg::cmd_t      cmd
);
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DIV_GO   = 5'd1;
	localparam logic [4:0] S_DIV_WAIT = 5'd2;
	localparam logic [4:0] S_WR       = 5'd3;
	localparam logic [4:0] S_FE       = 5'd4;
	localparam logic [4:0] S_SEL_INIT = 5'd5;
	localparam logic [4:0] S_SEL_RD   = 5'd6;
	localparam logic [4:0] S_SEL_EV   = 5'd7;
	localparam logic [4:0] S_SEL_DONE = 5'd8;
	localparam logic [4:0] S_A_RD     = 5'd9;
	localparam logic [4:0] S_A_LD     = 5'd10;
	localparam logic [4:0] S_EMIT     = 5'd11;
	localparam logic [4:0] S_B_RD     = 5'd12;
	localparam logic [4:0] S_B_EV     = 5'd13;
	localparam logic [4:0] S_I0       = 5'd14;
	localparam logic [4:0] S_I1       = 5'd15;
	localparam logic [4:0] S_I2       = 5'd16;
	localparam logic [4:0] S_I3       = 5'd17;
	localparam logic [4:0] S_I4       = 5'd18;
	localparam logic [4:0] S_I5       = 5'd19;
	localparam logic [4:0] S_I6       = 5'd20;
	localparam logic [4:0] S_I7       = 5'd21;
	localparam logic [4:0] S_I8       = 5'd22;
	localparam logic [4:0] S_B_NEXT   = 5'd23;
	localparam logic [4:0] S_END      = 5'd24;

	logic [4:0] state_q, state_d;
	logic [1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		k_d           = k_q;
		cmd           = '0;
		cmd.iou_step  = ssdn_pkg::IS_NONE;
		cmd.coord_sel = k_q;
		item_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (st.op)
						ssdn_pkg::OP_SCORE: cmd.score_upd = 1'b1;
						ssdn_pkg::OP_BOX: begin
							cmd.box_eval = 1'b1;
							k_d          = '0;
							if (st.qualify && st.room) state_d = st.norm ? S_WR : S_DIV_GO;
						end
						ssdn_pkg::OP_END: state_d = S_FE;
						default: ;
					endcase
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (st.div_done) begin
					cmd.div_store = 1'b1;
					k_d           = k_q + 2'd1;
					state_d       = (k_q == 2'd3) ? S_WR : S_DIV_GO;
				end
			end
			S_WR: begin
				cmd.row_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_FE: begin
				cmd.fe_init = 1'b1;
				state_d     = S_SEL_INIT;
			end
			S_SEL_INIT: begin
				cmd.sel_clr = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = st.n_zero ? S_END : S_SEL_RD;
			end
			S_SEL_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SEL_EV;
			end
			S_SEL_EV: begin
				cmd.sel_eval = 1'b1;
				if (st.idx_last) state_d = S_SEL_DONE;
				else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SEL_RD;
				end
			end
			S_SEL_DONE: begin
				if (!st.found) state_d = S_END;
				else begin
					cmd.take_best = 1'b1;
					state_d       = st.best_supp ? S_SEL_INIT : S_A_RD;
				end
			end
			S_A_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_bidx = 1'b1;
				state_d     = S_A_LD;
			end
			S_A_LD: begin
				cmd.a_load = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit_held = 1'b1;
					cmd.idx_clr   = 1'b1;
					state_d       = S_B_RD;
				end
			end
			S_B_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_B_EV;
			end
			S_B_EV: state_d = st.b_cand ? S_I0 : S_B_NEXT;
			S_I0: begin
				cmd.iou_step = ssdn_pkg::IS_DIFF;
				state_d      = S_I1;
			end
			S_I1: begin
				cmd.iou_step = ssdn_pkg::IS_M1;
				state_d      = S_I2;
			end
			S_I2: begin
				cmd.iou_step = ssdn_pkg::IS_M2;
				state_d      = S_I3;
			end
			S_I3: begin
				cmd.iou_step = ssdn_pkg::IS_M3;
				state_d      = S_I4;
			end
			S_I4: begin
				cmd.iou_step = ssdn_pkg::IS_M4;
				state_d      = S_I5;
			end
			S_I5: begin
				if (st.uni_pos) begin
					cmd.iou_step = ssdn_pkg::IS_M5;
					state_d      = S_I6;
				end else begin
					state_d = S_B_NEXT;
				end
			end
			S_I6: begin
				cmd.iou_step = ssdn_pkg::IS_M6;
				state_d      = S_I7;
			end
			S_I7: begin
				cmd.iou_step = ssdn_pkg::IS_M7;
				state_d      = S_I8;
			end
			S_I8: begin
				cmd.iou_step = ssdn_pkg::IS_CMP;
				state_d      = S_B_NEXT;
			end
			S_B_NEXT: begin
				if (st.idx_last) state_d = S_SEL_INIT;
				else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_B_RD;
				end
			end
			S_END: begin
				if (st.out_free) begin
					cmd.emit_end = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
